FILE: src/hslrgb_pkg.sv
// Shared constants and types for the HSL to RGB converter.
// Used by hsl_to_rgb_converter, hslrgb_byte_scale and the testbench files; depends on nothing else.
package hslrgb_pkg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ChromaW = 14;  // chroma in 1/10000 units, 0..10000
  localparam int unsigned FixW   = 20;   // components in 1/600000 units, 0..600000
  localparam int unsigned ScaledW = 25;  // 51 * v + 60000, below 2^25
  localparam int unsigned QuotW  = 19;   // scaled value divided by 64
  localparam int unsigned ProdW  = 33;

  localparam logic [HueW-1:0] HueFull   = 9'd360;
  localparam logic [HueW-1:0] SectorDeg = 9'd60;
  localparam logic [PctW-1:0] PctMax    = 7'd100;

  localparam logic [FixW-1:0] SectorScale = 20'd60;
  localparam logic [FixW-1:0] LightScale  = 20'd6000;
  localparam logic [FixW-1:0] HalfChroma  = 20'd30;
  localparam logic [FixW-1:0] UnitFull    = 20'd600000;

  // byte = floor((255 v + 300000) / 600000) = floor(floor((51 v + 60000) / 64) / 1875)
  localparam logic [ScaledW-1:0] ScaleMul   = 25'd51;
  localparam logic [ScaledW-1:0] RoundBias  = 25'd60000;
  localparam int unsigned        PreShift   = 6;
  localparam logic [QuotW-1:0]   DivRest    = 19'd1875;
  localparam logic [ProdW-1:0]   RecipK     = 33'd8947;  // floor(2^24 / 1875)
  localparam int unsigned        RecipShift = 24;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // Load enables for the three stages of the byte scaler.
  typedef struct packed {
    logic scale;
    logic est;
    logic fix;
  } scale_en_t;

endpackage

FILE: src/hsl_to_rgb_converter.sv
// HSL to RGB converter: hue in degrees, saturation and lightness in percent to 8-bit RGB.
// Throughput: one transaction per cycle while out_stall_i is low; each of the seven register
// stages holds its item under stall and empty stages fill, so no bubble is needed.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data registers are not reset.
// Depends on hslrgb_pkg and hslrgb_byte_scale.
module hsl_to_rgb_converter import hslrgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [HueW-1:0]  hue_degrees_i,
  input  logic [PctW-1:0]  saturation_pct_i,
  input  logic [PctW-1:0]  lightness_pct_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] red_o,
  output logic [ByteW-1:0] green_o,
  output logic [ByteW-1:0] blue_o
);

  localparam int unsigned NumStages = 7;

  logic [NumStages:1] valid_q;
  logic [NumStages:1] adv;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    adv[NumStages] = !valid_q[NumStages] || !out_stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[1]) begin
        valid_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !adv[1];
  assign out_valid_o = valid_q[NumStages];

  // Stage 1: clamp, hue sector, distance from the sector edge, lightness fold.
  logic [HueW-1:0] hue_r;
  logic [HueW-1:0] hue_p;
  logic [HueW-1:0] hue_d;
  logic [PctW-1:0] sat_c;
  logic [PctW-1:0] lit_c;
  logic [ByteW-1:0] lit2;
  logic [ByteW-1:0] lit_dev;
  sector_e          sector_d;

  always_comb begin
    hue_r = (hue_degrees_i >= HueFull) ? hue_degrees_i - HueFull : hue_degrees_i;
    priority if (hue_r < SectorDeg)        sector_d = SEC_RY;
    else if (hue_r < 9'd2 * SectorDeg)     sector_d = SEC_YG;
    else if (hue_r < 9'd3 * SectorDeg)     sector_d = SEC_GC;
    else if (hue_r < 9'd4 * SectorDeg)     sector_d = SEC_CB;
    else if (hue_r < 9'd5 * SectorDeg)     sector_d = SEC_BM;
    else                                   sector_d = SEC_MR;
    priority if (hue_r < 9'd2 * SectorDeg) hue_p = hue_r;
    else if (hue_r < 9'd4 * SectorDeg)     hue_p = hue_r - 9'd2 * SectorDeg;
    else                                   hue_p = hue_r - 9'd4 * SectorDeg;
    hue_d = (hue_p >= SectorDeg) ? hue_p - SectorDeg : SectorDeg - hue_p;
    sat_c = (saturation_pct_i > PctMax) ? PctMax : saturation_pct_i;
    lit_c = (lightness_pct_i > PctMax) ? PctMax : lightness_pct_i;
    lit2  = {lit_c, 1'b0};
    lit_dev = (lit2 >= ByteW'(PctMax)) ? lit2 - ByteW'(PctMax) : ByteW'(PctMax) - lit2;
  end

  sector_e          sector_q1;
  logic [5:0]       wgt_q1;
  logic [PctW-1:0]  span_q1;
  logic [PctW-1:0]  sat_q1;
  logic [PctW-1:0]  lit_q1;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sector_q1 <= sector_d;
      wgt_q1    <= 6'(SectorDeg - hue_d);
      span_q1   <= 7'(ByteW'(PctMax) - lit_dev);
      sat_q1    <= sat_c;
      lit_q1    <= lit_c;
    end
  end

  // Stage 2: chroma.
  sector_e             sector_q2;
  logic [5:0]          wgt_q2;
  logic [ChromaW-1:0]  chroma_q2;
  logic [PctW-1:0]     lit_q2;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sector_q2 <= sector_q1;
      wgt_q2    <= wgt_q1;
      chroma_q2 <= ChromaW'(span_q1) * ChromaW'(sat_q1);
      lit_q2    <= lit_q1;
    end
  end

  // Stage 3: primary, secondary and offset components.
  sector_e          sector_q3;
  logic [FixW-1:0]  cf_q3;
  logic [FixW-1:0]  xf_q3;
  logic [FixW-1:0]  mf_q3;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sector_q3 <= sector_q2;
      cf_q3     <= FixW'(chroma_q2) * SectorScale;
      xf_q3     <= FixW'(chroma_q2) * FixW'(wgt_q2);
      mf_q3     <= FixW'(lit_q2) * LightScale - FixW'(chroma_q2) * HalfChroma;
    end
  end

  // Stage 4: route components to channels and add the offset.
  logic [FixW-1:0] red_c;
  logic [FixW-1:0] grn_c;
  logic [FixW-1:0] blu_c;
  logic [FixW-1:0] sum_q4 [3];

  always_comb begin
    unique case (sector_q3)
      SEC_RY:  begin red_c = cf_q3; grn_c = xf_q3; blu_c = '0;    end
      SEC_YG:  begin red_c = xf_q3; grn_c = cf_q3; blu_c = '0;    end
      SEC_GC:  begin red_c = '0;    grn_c = cf_q3; blu_c = xf_q3; end
      SEC_CB:  begin red_c = '0;    grn_c = xf_q3; blu_c = cf_q3; end
      SEC_BM:  begin red_c = xf_q3; grn_c = '0;    blu_c = cf_q3; end
      default: begin red_c = cf_q3; grn_c = '0;    blu_c = xf_q3; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      sum_q4[0] <= red_c + mf_q3;
      sum_q4[1] <= grn_c + mf_q3;
      sum_q4[2] <= blu_c + mf_q3;
    end
  end

  // Stages 5 to 7: rounding and scaling to bytes, one lane per channel.
  scale_en_t        scale_en;
  logic [ByteW-1:0] byte_c [3];

  assign scale_en = '{scale: adv[5], est: adv[6], fix: adv[7]};

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    hslrgb_byte_scale u_scale (
      .clk_i  (clk_i),
      .en_i   (scale_en),
      .sum_i  (sum_q4[ch]),
      .byte_o (byte_c[ch])
    );
  end

  assign red_o   = byte_c[0];
  assign green_o = byte_c[1];
  assign blue_o  = byte_c[2];

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while a pipeline stage is empty");

  a_no_stall_without_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled although the output is not stalled");

  a_chroma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (chroma_q2 <= ChromaW'(10000)))
    else $error("chroma exceeds full scale");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> (sum_q4[0] <= UnitFull && sum_q4[1] <= UnitFull && sum_q4[2] <= UnitFull))
    else $error("channel sum exceeds full scale");

endmodule

FILE: src/hslrgb_byte_scale.sv
// Turns one channel value in 1/600000 units into a rounded byte.
// Three register stages: scale, reciprocal estimate, remainder correction. Uses hslrgb_pkg.
module hslrgb_byte_scale import hslrgb_pkg::*; (
  input  logic             clk_i,
  input  scale_en_t        en_i,
  input  logic [FixW-1:0]  sum_i,
  output logic [ByteW-1:0] byte_o
);

  logic [ScaledW-1:0] scaled;
  logic [QuotW-1:0]   t_q;
  logic [QuotW-1:0]   t2_q;
  logic [ByteW-1:0]   est_q;
  logic [ByteW-1:0]   byte_q;
  logic [ProdW-1:0]   prod;
  logic [QuotW-1:0]   rem;

  assign scaled = ScaledW'(sum_i) * ScaleMul + RoundBias;

  // The estimate is low by at most one, so one compare fixes it.
  assign prod = ProdW'(t_q) * RecipK;
  assign rem  = t2_q - QuotW'(est_q) * DivRest;

  always_ff @(posedge clk_i) begin
    if (en_i.scale) begin
      t_q <= scaled[ScaledW-1:PreShift];
    end
    if (en_i.est) begin
      t2_q  <= t_q;
      est_q <= prod[RecipShift+ByteW-1:RecipShift];
    end
    if (en_i.fix) begin
      byte_q <= est_q + ByteW'(rem >= DivRest);
    end
  end

  assign byte_o = byte_q;

endmodule

FILE: tb/hslrgb_checker.sv
`timescale 1ns / 1ps
// Checker for hsl_to_rgb_converter: watches both channels and predicts each color.
// Compares every output transaction with the oldest prediction. Depends on hslrgb_pkg.
module hslrgb_checker import hslrgb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [HueW-1:0]  hue_i,
  input  logic [PctW-1:0]  sat_i,
  input  logic [PctW-1:0]  light_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ByteW-1:0] red_i,
  input  logic [ByteW-1:0] green_i,
  input  logic [ByteW-1:0] blue_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct {
    logic [HueW-1:0]  hue;
    logic [PctW-1:0]  sat;
    logic [PctW-1:0]  light;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } color_t;

  color_t rgb_due_q[$];
  color_t due;
  int     failures = 0;
  int     pending  = 0;

  assign fail_count_o = failures;
  assign pending_o    = pending;

  // Components are in units of 1/600000; round half up to a byte.
  function automatic logic [ByteW-1:0] byte_of_fixed(input int unsigned v);
    return ByteW'((255 * v + 32'(UnitFull) / 2) / 32'(UnitFull));
  endfunction

  function automatic color_t rgb_from_hsl(input logic [HueW-1:0] hue,
                                          input logic [PctW-1:0] sat,
                                          input logic [PctW-1:0] light);
    int unsigned h, s, l, dev, chroma, cf, hp, hd, xf, mf, rc, gc, bc;
    int unsigned pct_max, sector_deg;
    sector_e     sector;
    color_t      col;
    pct_max    = 32'(PctMax);
    sector_deg = 32'(SectorDeg);
    h = 32'(hue) % 32'(HueFull);
    s = (32'(sat) > pct_max) ? pct_max : 32'(sat);
    l = (32'(light) > pct_max) ? pct_max : 32'(light);
    dev    = (2 * l >= pct_max) ? (2 * l - pct_max) : (pct_max - 2 * l);
    chroma = (pct_max - dev) * s;
    cf     = 32'(SectorScale) * chroma;
    hp     = h % (2 * sector_deg);
    hd     = (hp >= sector_deg) ? (hp - sector_deg) : (sector_deg - hp);
    xf     = chroma * (sector_deg - hd);
    mf     = 32'(LightScale) * l - 32'(HalfChroma) * chroma;
    sector = sector_e'(3'(h / sector_deg));
    case (sector)
      SEC_RY: begin rc = cf; gc = xf; bc = 0;  end
      SEC_YG: begin rc = xf; gc = cf; bc = 0;  end
      SEC_GC: begin rc = 0;  gc = cf; bc = xf; end
      SEC_CB: begin rc = 0;  gc = xf; bc = cf; end
      SEC_BM: begin rc = xf; gc = 0;  bc = cf; end
      default: begin rc = cf; gc = 0; bc = xf; end
    endcase
    col.hue   = hue;
    col.sat   = sat;
    col.light = light;
    col.red   = byte_of_fixed(rc + mf);
    col.green = byte_of_fixed(gc + mf);
    col.blue  = byte_of_fixed(bc + mf);
    return col;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_due_q.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rgb_due_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected color rgb %0d %0d %0d", $time, red_i, green_i, blue_i);
        end else begin
          due = rgb_due_q.pop_front();
          if (red_i !== due.red || green_i !== due.green || blue_i !== due.blue) begin
            failures++;
            $display("%0t: hsl %0d %0d %0d expected rgb %0d %0d %0d, got %0d %0d %0d",
                     $time, due.hue, due.sat, due.light, due.red, due.green, due.blue,
                     red_i, green_i, blue_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        rgb_due_q.push_back(rgb_from_hsl(hue_i, sat_i, light_i));
      end
      pending = rgb_due_q.size();
    end
  end

endmodule

FILE: tb/tb_hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// Testbench top for hsl_to_rgb_converter: drives directed and random colors with random idling.
// Depends on hslrgb_pkg, hsl_to_rgb_converter and hslrgb_checker.
module tb_hsl_to_rgb_converter;
  import hslrgb_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomColors = 1150;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [HueW-1:0]  hue = '0;
  logic [PctW-1:0]  sat = '0;
  logic [PctW-1:0]  light = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ByteW-1:0] red, green, blue;
  int               fail_count, pending;
  int               cycles = 0;
  bit               idle_tx = 1'b1;

  always #5 clk = ~clk;

  hsl_to_rgb_converter u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .hue_degrees_i   (hue),
    .saturation_pct_i(sat),
    .lightness_pct_i (light),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue)
  );

  hslrgb_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .hue_i       (hue),
    .sat_i       (sat),
    .light_i     (light),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
      $display("** hsl_to_rgb_converter: FAILED **");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_color(input logic [HueW-1:0] h, input logic [PctW-1:0] s,
                            input logic [PctW-1:0] l);
    int gap;
    if ($urandom_range(0, 31) == 0) idle_tx = !idle_tx;
    gap = idle_tx ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    hue      <= h;
    sat      <= s;
    light    <= l;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  initial begin : color_source
    logic [HueW-1:0] h;
    logic [PctW-1:0] s, l;
    int pick;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_color(9'd0,   7'd0,   7'd0);    // black
    send_color(9'd0,   7'd100, 7'd100);  // white
    send_color(9'd0,   7'd100, 7'd50);   // pure red
    send_color(9'd60,  7'd100, 7'd50);
    send_color(9'd120, 7'd100, 7'd50);
    send_color(9'd180, 7'd100, 7'd50);
    send_color(9'd240, 7'd100, 7'd50);
    send_color(9'd300, 7'd100, 7'd50);
    send_color(9'd359, 7'd100, 7'd50);
    send_color(9'd360, 7'd100, 7'd50);   // wraps to red
    send_color(9'd511, 7'd127, 7'd127);  // all input bits set
    send_color(9'd256, 7'd64,  7'd63);
    send_color(9'd30,  7'd127, 7'd50);   // saturation clamped
    send_color(9'd90,  7'd50,  7'd101);  // lightness clamped
    send_color(9'd150, 7'd101, 7'd75);
    send_color(9'd210, 7'd80,  7'd60);
    send_color(9'd270, 7'd33,  7'd67);
    send_color(9'd330, 7'd100, 7'd1);
    send_color(9'd45,  7'd1,   7'd99);
    send_color(9'd419, 7'd100, 7'd25);
    send_color(9'd199, 7'd0,   7'd50);   // grey, no chroma

    for (int n = 0; n < RandomColors; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        h = HueW'($urandom_range(0, 359));
        s = PctW'($urandom_range(0, 100));
        l = PctW'($urandom_range(0, 100));
      end else if (pick < 77) begin
        // Hues right around the sector boundaries.
        h = HueW'((60 * $urandom_range(1, 6) - 1 + $urandom_range(0, 2)) % 360);
        s = PctW'($urandom_range(0, 100));
        l = PctW'($urandom_range(0, 100));
      end else if (pick < 90) begin
        h = HueW'($urandom_range(0, 511));
        s = PctW'($urandom_range(0, 127));
        l = PctW'($urandom_range(0, 127));
      end else begin
        h = HueW'($urandom_range(0, 359));
        case ($urandom_range(0, 2))
          0: s = 7'd0;
          1: s = 7'd100;
          default: s = 7'd127;
        endcase
        case ($urandom_range(0, 3))
          0: l = 7'd0;
          1: l = 7'd50;
          2: l = 7'd100;
          default: l = 7'd127;
        endcase
      end
      send_color(h, s, l);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("** hsl_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsl_to_rgb_converter: FAILED **");
    end
    $finish;
  end

  initial begin : color_sink
    int  gap;
    int  taken;
    bit  idle_rx;
    taken   = 0;
    idle_rx = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) idle_rx = !idle_rx;
      gap = idle_rx ? $urandom_range(0, 15) : 0;
      // Two long hold-offs let the pipeline fill and push back on the source.
      if (taken == 200 || taken == 700) gap = 250;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
      @(negedge clk);
    end
  end

endmodule
